// File: rtl/pll_output_rate_calc_assert.svh
// Assertion macros used by the top-level RTL file.
`ifndef PLL_OUTPUT_RATE_CALC_ASSERT_SVH
`define PLL_OUTPUT_RATE_CALC_ASSERT_SVH

// Check a property on every clock edge outside of reset.
`define PORC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PORC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/porc_pkg.sv
package porc_pkg;

  localparam int unsigned RefW     = 25;
  localparam int unsigned DivW     = 32;
  localparam int unsigned ProdW    = 57;
  localparam int unsigned RateW    = 41;
  localparam int unsigned FracBits = 16;
  localparam int unsigned NumCells = ProdW;

  localparam logic [31:0] RefRateMax = 32'd24000000;

  // Configuration register indexes.
  localparam logic CfgPllType    = 1'b0;
  localparam logic CfgParentRate = 1'b1;

  // Payload handed from one divider cell to the next.
  typedef struct packed {
    logic             frac;  // fractional PLL type
    logic             zero;  // divisor was zero
    logic [DivW-1:0]  div;
    logic [DivW-1:0]  rem;
    logic [ProdW-1:0] word;  // dividend bits on top, quotient bits shifted in below
  } porc_cell_t;

endpackage

// File: rtl/porc_div_cell.sv
module porc_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  porc_pkg::porc_cell_t cell_i,
  output logic                valid_o,
  output porc_pkg::porc_cell_t cell_o
);
  import porc_pkg::*;

  logic                valid_q;
  porc_cell_t          cell_d, cell_q;
  logic [DivW:0]       trial;
  logic [DivW:0]       diff;
  logic                ge;

  // One restoring division step: bring down the next dividend bit.
  always_comb begin
    trial  = {cell_i.rem, cell_i.word[ProdW-1]};
    diff   = trial - {1'b0, cell_i.div};
    ge     = !diff[DivW];
    cell_d = cell_i;
    cell_d.rem  = ge ? diff[DivW-1:0] : trial[DivW-1:0];
    cell_d.word = {cell_i.word[ProdW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

// File: rtl/porc_front.sv
module porc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic                frac_mode_i,
  input  logic [31:0]         ref_clk_i,
  input  logic [15:0]         pre_div_i,
  input  logic [15:0]         mult_i,
  input  logic [4:0]          post_shift_i,
  input  logic signed [15:0]  frac_i,
  output logic                valid_o,
  output porc_pkg::porc_cell_t cell_o
);
  import porc_pkg::*;

  logic                valid_q;
  porc_cell_t          cell_d, cell_q;
  logic [RefW-1:0]     ref_rate;
  logic [31:0]         mul;
  logic [46:0]         div_wide;
  logic [DivW-1:0]     divisor;
  logic [ProdW-1:0]    prod;

  always_comb begin
    ref_rate = (ref_clk_i > RefRateMax) ? RefRateMax[RefW-1:0] : ref_clk_i[RefW-1:0];
    if (frac_mode_i) begin
      mul = {mult_i, 16'h0000} + {{16{frac_i[15]}}, frac_i};
    end else begin
      mul = {16'h0000, mult_i};
    end
    div_wide = {31'd0, pre_div_i} << post_shift_i;
    divisor  = div_wide[DivW-1:0];
    prod     = {{(ProdW-RefW){1'b0}}, ref_rate} * {{(ProdW-32){1'b0}}, mul};
    cell_d.frac = frac_mode_i;
    cell_d.zero = (divisor == '0);
    cell_d.div  = divisor;
    cell_d.rem  = '0;
    cell_d.word = prod;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

// File: rtl/pll_output_rate_calc.sv
// Datapath: one multiply stage, 57 divider cells with one quotient bit each,
// and one output register.
// Throughput: one item per cycle; the whole chain advances together and holds
// while a result waits on m_axis_tready_i.
// Reset (rst_ni low, asynchronous) empties the chain, selects the integer type
// and sets the reference to 24000000 Hz.
`include "pll_output_rate_calc_assert.svh"

module pll_output_rate_calc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // pre_div[15:0], mult[31:16], post_shift[36:32], frac[52:37], zero pad
  input  logic [55:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // rate[40:0], zero_divisor[41], zero pad
  output logic [47:0] m_axis_tdata_o
);
  import porc_pkg::*;

  logic             frac_mode_q;
  logic [31:0]      ref_clk_q;
  logic             advance;
  logic             cell_valid [NumCells+1];
  porc_cell_t       cell_data  [NumCells+1];
  logic             out_valid_q;
  logic [47:0]      out_data_q;
  logic [ProdW-1:0] quot;
  logic [RateW-1:0] rate;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_mode_q <= 1'b0;
      ref_clk_q   <= RefRateMax;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgPllType:    frac_mode_q <= cfg_wdata_i[0];
        CfgParentRate: ref_clk_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Advance the chain whenever the output slot is free or being drained.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = advance;

  porc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .valid_i      (s_axis_tvalid_i),
    .frac_mode_i  (frac_mode_q),
    .ref_clk_i    (ref_clk_q),
    .pre_div_i    (s_axis_tdata_i[15:0]),
    .mult_i       (s_axis_tdata_i[31:16]),
    .post_shift_i (s_axis_tdata_i[36:32]),
    .frac_i       (s_axis_tdata_i[52:37]),
    .valid_o      (cell_valid[0]),
    .cell_o       (cell_data[0])
  );

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    porc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .valid_i(cell_valid[g]),
      .cell_i (cell_data[g]),
      .valid_o(cell_valid[g+1]),
      .cell_o (cell_data[g+1])
    );
  end

  always_comb begin
    quot = cell_data[NumCells].word;
    if (cell_data[NumCells].zero) begin
      rate = '0;
    end else if (cell_data[NumCells].frac) begin
      rate = RateW'(quot >> FracBits);
    end else begin
      rate = quot[RateW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= cell_valid[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {6'd0, cell_data[NumCells].zero, rate};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `PORC_ASSERT(a_stall_blocks_input, (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o, "input taken while output stalled")
  `PORC_ASSERT(a_zero_rate, (m_axis_tvalid_o && m_axis_tdata_o[41]) |-> (m_axis_tdata_o[40:0] == '0), "nonzero rate on zero divisor")
  `PORC_ASSERT(a_accept_enters, (s_axis_tvalid_i && s_axis_tready_o) |=> cell_valid[0], "accepted item lost at chain entry")
  `PORC_ASSERT_ALWAYS(a_reset_empty, $past(!rst_ni) |-> !out_valid_q, "result shown right after reset")

endmodule

// File: dv/pll_output_rate_calc_checker.sv
`timescale 1ns / 1ps

module pll_output_rate_calc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  // pre_div[15:0], mult[31:16], post_shift[36:32], frac[52:37], zero pad
  input  logic [55:0] s_data_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  // rate[40:0], zero_divisor[41], zero pad
  input  logic [47:0] m_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  import porc_pkg::*;

  typedef struct packed {
    logic [RateW-1:0] rate;
    logic             zero_div;
  } pll_rate_t;

  pll_rate_t   rate_q[$];
  logic        frac_mode;
  logic [31:0] parent_hz;

  function automatic pll_rate_t calc_pll_rate(input logic [15:0] pre_div,
                                              input logic [15:0] mult,
                                              input logic [4:0]  post_shift,
                                              input logic [15:0] frac,
                                              input logic        is_frac,
                                              input logic [31:0] parent);
    logic [63:0] ref_hz;
    logic [63:0] shifted;
    logic [31:0] divisor;
    logic [31:0] mul;
    logic [63:0] prod;
    logic [63:0] quot;
    pll_rate_t   res;
    ref_hz  = (parent > RefRateMax) ? {32'd0, RefRateMax} : {32'd0, parent};
    shifted = {48'd0, pre_div} << post_shift;
    divisor = shifted[31:0];
    // the multiplier wraps at 32 bits, so m = 0 with negative k gets large
    if (is_frac) begin
      mul = {mult, 16'd0} + {{16{frac[15]}}, frac};
    end else begin
      mul = {16'd0, mult};
    end
    prod = ref_hz * {32'd0, mul};
    if (divisor == '0) begin
      res.rate     = '0;
      res.zero_div = 1'b1;
    end else begin
      quot = prod / {32'd0, divisor};
      if (is_frac) begin
        quot = quot >> FracBits;
      end
      res.rate     = quot[RateW-1:0];
      res.zero_div = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pll_rate_t exp_res;
    if (!rst_ni) begin
      rate_q.delete();
      frac_mode    = 1'b0;
      parent_hz    = RefRateMax;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (rate_q.size() == 0) begin
          $display("%t unexpected result: rate %0d, zero_divisor %0b", $time,
                   m_data_i[40:0], m_data_i[41]);
          fail_count_o++;
        end else begin
          exp_res = rate_q.pop_front();
          if (m_data_i[40:0] !== exp_res.rate) begin
            $display("%t rate mismatch: expected %0d, actual %0d", $time,
                     exp_res.rate, m_data_i[40:0]);
            fail_count_o++;
          end
          if (m_data_i[41] !== exp_res.zero_div) begin
            $display("%t zero_divisor mismatch: expected %0b, actual %0b", $time,
                     exp_res.zero_div, m_data_i[41]);
            fail_count_o++;
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        rate_q.push_back(calc_pll_rate(s_data_i[15:0], s_data_i[31:16], s_data_i[36:32],
                                       s_data_i[52:37], frac_mode, parent_hz));
      end
      if (cfg_we_i) begin
        if (cfg_addr_i == CfgPllType) begin
          frac_mode = cfg_wdata_i[0];
        end else if (cfg_addr_i == CfgParentRate) begin
          parent_hz = cfg_wdata_i;
        end
      end
      pending_o = rate_q.size();
    end
  end

endmodule

// File: dv/pll_output_rate_calc_tb.sv
`timescale 1ns / 1ps

module pll_output_rate_calc_tb;
  import porc_pkg::*;

  localparam int WatchLimit = 5000;
  localparam int HoldCycles = 400;
  localparam int TailCycles = 70;

  typedef struct packed {
    logic [15:0] pre_div;
    logic [15:0] mult;
    logic [4:0]  post_shift;
    logic [15:0] frac;
  } pll_set_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic        cfg_addr;
  logic [31:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  int fail_count;
  int pending;

  pll_set_t settings_q[$];
  int       queued_cnt;
  int       accepted_cnt;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       hold_seq;

  pll_output_rate_calc dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  pll_output_rate_calc_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sender: offer queued settings, idling at random between items
  initial begin
    pll_set_t it;
    logic     fire;
    accepted_cnt = 0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    forever begin
      @(posedge clk_i);
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) begin
        accepted_cnt++;
      end
      if (!s_axis_tvalid || fire) begin
        if (settings_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          it = settings_q.pop_front();
          s_axis_tdata  <= {3'b000, it.frac, it.post_shift, it.mult, it.pre_div};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    int seen_seq;
    hold_left = 0;
    seen_seq  = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    do begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end while (quiet < WatchLimit);
    $display("pll_output_rate_calc test failed");
    $finish;
  end

  task automatic add_item(input logic [15:0] pre_div, input logic [15:0] mult,
                          input logic [4:0] post_shift, input logic [15:0] frac);
    pll_set_t it;
    it.pre_div    = pre_div;
    it.mult       = mult;
    it.post_shift = post_shift;
    it.frac       = frac;
    settings_q.push_back(it);
    queued_cnt++;
  endtask

  // mostly small dividers and shifts so that rates stay nonzero
  task automatic add_random(input int count);
    logic [15:0] pre_div;
    logic [15:0] mult;
    logic [4:0]  post_shift;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0:       pre_div = '0;
        1, 2, 3: pre_div = 16'($urandom_range(1, 15));
        4, 5:    pre_div = 16'($urandom_range(16, 255));
        default: pre_div = 16'($urandom);
      endcase
      mult = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 255)) : 16'($urandom);
      post_shift = ($urandom_range(9) < 7) ? 5'($urandom_range(0, 6))
                                           : 5'($urandom_range(0, 31));
      add_item(pre_div, mult, post_shift, 16'($urandom));
    end
  endtask

  // sample at the falling edge, after all rising-edge updates have settled
  task automatic drain_results();
    do @(negedge clk_i); while (accepted_cnt != queued_cnt || pending != 0);
  endtask

  task automatic write_reg(input logic addr, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_phase(input logic is_frac, input logic [31:0] parent,
                           input int idle_pct, input int stall_pct);
    write_reg(CfgPllType, {31'd0, is_frac});
    write_reg(CfgParentRate, parent);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  initial begin
    queued_cnt     = 0;
    hold_seq       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CfgPllType;
    cfg_wdata <= '0;
    rst_ni    <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // integer type with the reset reference
    add_item(16'd0, 16'd100, 5'd0, 16'h0000);       // zero divisor
    add_item(16'd0, 16'hFFFF, 5'd31, 16'hFFFF);
    add_item(16'd1, 16'd0, 5'd0, 16'h0000);
    add_item(16'd1, 16'hFFFF, 5'd0, 16'h7FFF);      // largest rate, frac ignored
    add_item(16'hFFFF, 16'hFFFF, 5'd31, 16'h8000);  // divisor wraps to top bit
    add_item(16'd2, 16'd1000, 5'd31, 16'h0000);     // divisor truncates to zero
    add_item(16'h8000, 16'd50, 5'd17, 16'h0000);
    add_item(16'hFFFF, 16'd40000, 5'd16, 16'h0000); // shifted divisor fills the upper 16 bits
    add_item(16'd3, 16'd7, 5'd5, 16'h1234);
    add_item(16'hFFFF, 16'd1, 5'd0, 16'h0000);
    add_item(16'd1, 16'd1, 5'd1, 16'h0000);
    add_random(50);
    drain_results();

    // fractional type, reference far above the clamp
    set_phase(1'b1, 32'hFFFF_FFFF, 0, 0);
    add_item(16'd1, 16'd0, 5'd0, 16'hFFFF);         // m zero, negative k: huge multiplier
    add_item(16'd1, 16'd0, 5'd0, 16'h8000);
    add_item(16'd1, 16'hFFFF, 5'd0, 16'h7FFF);
    add_item(16'd1, 16'hFFFF, 5'd0, 16'h8000);
    add_item(16'd1, 16'd0, 5'd0, 16'h0001);
    add_item(16'd0, 16'd500, 5'd3, 16'h1000);
    add_item(16'd7, 16'd300, 5'd2, 16'hFF00);
    add_item(16'hFFFF, 16'hFFFF, 5'd31, 16'hFFFF);
    add_item(16'd1, 16'd100, 5'd0, 16'h0000);
    add_item(16'd3, 16'd20, 5'd1, 16'h8001);
    add_random(50);
    drain_results();

    set_phase(1'b1, RefRateMax, 64, 0);
    add_random(60);
    drain_results();

    set_phase(1'b0, 32'd0, 0, 64);
    add_random(55);
    drain_results();

    set_phase(1'b1, 32'd1, 10, 10);
    add_random(55);
    drain_results();

    // hold the output long enough for the chain to fill and stall the input
    set_phase(1'b0, RefRateMax + 32'd1, 0, 0);
    hold_seq++;
    add_random(100);
    drain_results();

    // pause the sender halfway until the chain is empty
    set_phase(1'b1, 32'($urandom_range(0, 30000000)), 0, 64);
    add_random(30);
    drain_results();
    add_random(30);
    drain_results();

    set_phase(1'b0, 32'hFFFF_FFFF, 10, 10);
    add_random(50);
    drain_results();

    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("pll_output_rate_calc test passed");
    end else begin
      $display("pll_output_rate_calc test failed");
    end
    $finish;
  end

endmodule
